// File: hdl/grc_pkg.sv
// shared types and constants for the grid rectangle cell replication block
// no dependencies
package grc_pkg;

  localparam int CFG_W   = 4;
  localparam int COORD_W = 17;
  localparam int ID_W    = 6;
  localparam int FIELD_W = 24;
  localparam int AXIS_W  = 3;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_COUNT = 2'd1,
    ACT_PLACE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [AXIS_W-1:0] xs;
    logic [AXIS_W-1:0] ys;
    logic [AXIS_W-1:0] xe;
    logic [AXIS_W-1:0] ye;
    logic [ID_W-1:0]   query;
  } entry_t;

endpackage

// File: hdl/grc_if.sv
// request and result channel interfaces with valid/ready handshake
// depends on grc_pkg
interface grc_item_if;
  import grc_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [COORD_W-1:0] x_low;
  logic [COORD_W-1:0] y_low;
  logic [COORD_W-1:0] x_high;
  logic [COORD_W-1:0] y_high;
  logic [ID_W-1:0]    query_cell;

  modport source (output valid, action, x_low, y_low, x_high, y_high, query_cell,
                  input ready);
  modport sink   (input valid, action, x_low, y_low, x_high, y_high, query_cell,
                  output ready);
endinterface

interface grc_result_if;
  import grc_pkg::*;
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    cell_id;
  logic [FIELD_W-1:0] slot;
  logic [FIELD_W-1:0] cell_count;
  logic               last;

  modport source (output valid, cell_id, slot, cell_count, last, input ready);
  modport sink   (input valid, cell_id, slot, cell_count, last, output ready);
endinterface

// File: hdl/grc_front.sv
// front end: accepts requests and maps rectangle corners to cell spans
// depends on grc_pkg and grc_item_if
module grc_front (
  grc_item_if.sink                   item,
  input  logic [grc_pkg::CFG_W-1:0]  n,
  output logic                       push_valid,
  input  logic                       push_ready,
  output grc_pkg::entry_t            push_data
);
  import grc_pkg::*;

  function automatic logic [AXIS_W-1:0] axis_cell(input logic [COORD_W-1:0] coord,
                                                  input logic [CFG_W-1:0] cnt);
    logic [COORD_W+CFG_W-1:0] prod;
    logic [CFG_W:0]           c;
    logic [CFG_W-1:0]         nm1;
    prod = (COORD_W+CFG_W)'(coord) * (COORD_W+CFG_W)'(cnt);
    c    = prod[COORD_W+CFG_W-1:COORD_W-1];
    nm1  = cnt - CFG_W'(1);
    if (c > (CFG_W+1)'(nm1)) begin
      c = (CFG_W+1)'(nm1);
    end
    return AXIS_W'(c);
  endfunction

  logic [AXIS_W-1:0] xs, ys, xe, ye;

  always_comb begin
    xs = axis_cell(item.x_low, n);
    ys = axis_cell(item.y_low, n);
    xe = axis_cell(item.x_high, n);
    ye = axis_cell(item.y_high, n);
    if (xe < xs) begin
      xe = xs;
    end
    if (ye < ys) begin
      ye = ys;
    end
    push_data.action = action_t'(item.action);
    push_data.xs     = xs;
    push_data.ys     = ys;
    push_data.xe     = xe;
    push_data.ye     = ye;
    push_data.query  = item.query_cell;
  end

  assign push_valid = item.valid;
  assign item.ready = push_ready;

endmodule

// File: hdl/grc_queue.sv
// two-entry queue between front end and cell engine
// depends on grc_pkg
module grc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  grc_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output grc_pkg::entry_t pop_data
);
  import grc_pkg::*;

  entry_t     store [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push, do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = store[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hdl/grc_back.sv
// cell engine: walks cell spans, updates counter and slot memories, drives results
// depends on grc_pkg and grc_result_if
module grc_back #(
  parameter int MAX_CELLS_PER_DIM = 8,
  parameter int COUNT_WIDTH       = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [grc_pkg::CFG_W-1:0] n,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  grc_pkg::entry_t           pop_data,
  grc_result_if.source              result
);
  import grc_pkg::*;

  localparam int CELLS = MAX_CELLS_PER_DIM * MAX_CELLS_PER_DIM;
  localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int LW    = 2 * CFG_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t                 state;
  entry_t                 cur;
  logic [AXIS_W-1:0]      x, y;
  logic [IW-1:0]          addr_q;
  logic [COUNT_WIDTH-1:0] cnt_mem [CELLS];
  logic [COUNT_WIDTH-1:0] pos_mem [CELLS];
  logic [CELLS-1:0]       cnt_vld, pos_vld;
  logic [COUNT_WIDTH-1:0] rd_cnt, rd_pos;

  logic                   o_valid;
  logic [ID_W-1:0]        o_id;
  logic [FIELD_W-1:0]     o_slot, o_count;
  logic                   o_last;

  logic [LW-1:0]          lin;
  logic [IW-1:0]          rd_addr;
  logic                   in_range;
  logic [COUNT_WIDTH-1:0] cnt_val, pos_val;
  logic                   at_end, emits, out_free, step, cnt_we, pos_we, clear_all;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  always_comb begin
    lin       = LW'(y) * LW'(n) + LW'(x);
    rd_addr   = (cur.action == ACT_READ) ? IW'(cur.query) : IW'(lin);
    in_range  = LW'(cur.query) < LW'(n) * LW'(n);
    cnt_val   = cnt_vld[addr_q] ? rd_cnt : '0;
    pos_val   = pos_vld[addr_q] ? rd_pos : '0;
    at_end    = (x == cur.xe) && (y == cur.ye);
    emits     = (cur.action == ACT_PLACE) || (cur.action == ACT_READ);
    out_free  = !o_valid || result.ready;
    step      = (state == S_WRITE) && (!emits || out_free);
    cnt_we    = step && (cur.action == ACT_COUNT);
    pos_we    = step && (cur.action == ACT_PLACE);
    pop_ready = (state == S_IDLE);
    clear_all = (state == S_IDLE) && pop_valid && (pop_data.action == ACT_CLEAR);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
      cnt_vld <= '0;
      pos_vld <= '0;
    end else begin
      if (step && emits) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
      if (clear_all) begin
        cnt_vld <= '0;
        pos_vld <= '0;
      end
      if (cnt_we) begin
        cnt_vld[addr_q] <= 1'b1;
      end
      if (pos_we) begin
        pos_vld[addr_q] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (pop_valid && pop_data.action != ACT_CLEAR) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (step) begin
            if (cur.action == ACT_READ || at_end) begin
              state <= S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // span walk and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && pop_valid) begin
      cur <= pop_data;
      x   <= pop_data.xs;
      y   <= pop_data.ys;
    end
    if (state == S_READ) begin
      addr_q <= rd_addr;
    end
    if (step) begin
      if (y < cur.ye) begin
        y <= y + AXIS_W'(1);
      end else begin
        y <= cur.ys;
        x <= x + AXIS_W'(1);
      end
    end
    if (step && emits) begin
      if (cur.action == ACT_READ) begin
        o_id    <= cur.query;
        o_slot  <= '0;
        o_count <= in_range ? FIELD_W'(cnt_val) : '0;
        o_last  <= 1'b1;
      end else begin
        o_id    <= ID_W'(addr_q);
        o_slot  <= FIELD_W'(pos_val);
        o_count <= '0;
        o_last  <= at_end;
      end
    end
  end

  // counter and slot memories
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_cnt <= cnt_mem[rd_addr];
      rd_pos <= pos_mem[rd_addr];
    end
    if (cnt_we) begin
      cnt_mem[addr_q] <= sat_inc(cnt_val);
    end
    if (pos_we) begin
      pos_mem[addr_q] <= sat_inc(pos_val);
    end
  end

  assign result.valid      = o_valid;
  assign result.cell_id    = o_id;
  assign result.slot       = o_slot;
  assign result.cell_count = o_count;
  assign result.last       = o_last;

endmodule

// File: hdl/grid_rectangle_cell_replication.sv
// Grid rectangle cell replication. Each request names a rectangle in the unit square
// (corners in 1.16 fixed point) and an action: clear all counters and slots, count the rectangle
// into every covered cell, place it (one result per covered cell with the cell id and
// that cell's next slot, x outer, y inner, last marking the final one), or read one
// cell's count. The front end maps corners to cell spans; a two-entry queue holds
// up to two requests. The cell engine takes each covered cell, or the read cell,
// through a read and a write state, a read-modify-write of the counter and slot
// memories through their registered read port. The user must write cells_per_dim
// through cfg_we/cfg_wdata only while the block is idle; it is not enforced.
module grid_rectangle_cell_replication #(
  parameter int MAX_CELLS_PER_DIM = 8,
  parameter int COUNT_WIDTH       = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [grc_pkg::CFG_W-1:0] cfg_wdata,
  grc_item_if.sink                  item,
  grc_result_if.source              result
);
  import grc_pkg::*;

  logic [CFG_W-1:0] cells_per_dim;
  logic [CFG_W-1:0] n;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  entry_t           push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_per_dim <= CFG_W'(8);
    end else if (cfg_we) begin
      cells_per_dim <= cfg_wdata;
    end
  end

  // effective grid size
  always_comb begin
    if (cells_per_dim == '0) begin
      n = CFG_W'(1);
    end else if (cells_per_dim > CFG_W'(MAX_CELLS_PER_DIM)) begin
      n = CFG_W'(MAX_CELLS_PER_DIM);
    end else begin
      n = cells_per_dim;
    end
  end

  grc_front u_front (
    .item       (item),
    .n          (n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  grc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  grc_back #(
    .MAX_CELLS_PER_DIM (MAX_CELLS_PER_DIM),
    .COUNT_WIDTH       (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .n         (n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule
